// ----- rtl/cssc_pkg.sv -----
// ----------------------------------------------------------------------------
// cssc_pkg
// Shared types, field positions and widths of the CAN signal scale codec.
// ----------------------------------------------------------------------------
`default_nettype none

package cssc_pkg;

   // fixed-point format of physical values
   localparam int FRAC_BITS = 8;
   localparam int PHYS_W    = 56;
   localparam int PAY_W     = 64;
   localparam int SCALE_W   = 16;
   localparam int FIELD_W   = 32;
   localparam int POS_W     = 6;
   localparam int OPC_W     = 2;

   // arithmetic unit widths
   localparam int ACC_W     = PHYS_W + SCALE_W;          // write product a*div
   localparam int OPA_W     = PHYS_W;                    // magnitude into the multiplier
   localparam int DIFF_W    = PHYS_W + 1;                // signed sum before magnitude
   localparam int DVSR_W    = SCALE_W + FRAC_BITS;       // largest divisor
   localparam int RD_PROD_W = FIELD_W + 1 + SCALE_W;     // |raw+offset| * mult
   localparam int RD_STEPS  = RD_PROD_W + FRAC_BITS;     // quotient bits on a read
   localparam int WR_STEPS  = 50;                        // quotient bits on a write
   localparam int MAG_W     = RD_STEPS + 1;              // rounded magnitude
   localparam int CNT_W     = $clog2(RD_STEPS);
   localparam int BIG_SHIFT = 33;                        // write quotient cap 2^33
   localparam int BIG_W     = DVSR_W + BIG_SHIFT + 1;

   // request tdata layout, lowest bit first
   localparam int RQ_LOAD_LSB = 0;
   localparam int RQ_OFS_LSB  = RQ_LOAD_LSB + PAY_W;
   localparam int RQ_LEN_LSB  = RQ_OFS_LSB + POS_W;
   localparam int RQ_MULT_LSB = RQ_LEN_LSB + POS_W;
   localparam int RQ_DIV_LSB  = RQ_MULT_LSB + SCALE_W;
   localparam int RQ_SOFF_LSB = RQ_DIV_LSB + SCALE_W;
   localparam int RQ_PHYS_LSB = RQ_SOFF_LSB + SCALE_W;
   localparam int REQ_DATA_W  = ((RQ_PHYS_LSB + PHYS_W + 7) / 8) * 8;
   localparam int REQ_USER_W  = OPC_W + 1;
   localparam int RQ_SGN_BIT  = OPC_W;

   // response layout
   localparam int RSP_DATA_W  = ((PHYS_W + PAY_W + 7) / 8) * 8;
   localparam int RSP_USER_W  = 2;

   typedef enum logic [OPC_W-1:0] {
      OP_LOAD  = 2'd0,
      OP_READ  = 2'd1,
      OP_WRITE = 2'd2
   } opcode_type;

   typedef enum logic [2:0] {
      AR_HOLD,
      AR_MUL_LOAD,
      AR_MUL_STEP,
      AR_DIV_LOAD,
      AR_DIV_STEP,
      AR_ROUND
   } arith_op_type;

   typedef struct packed {
      arith_op_type op;
      logic         wr_mode;
   } arith_cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SETUP,
      ST_ABS,
      ST_MUL,
      ST_DIV_LOAD,
      ST_DIV,
      ST_ROUND,
      ST_CLAMP,
      ST_OUT
   } state_type;

   // length 0 acts as 1, anything above 32 acts as 32
   function automatic logic [POS_W-1:0] eff_len(input logic [POS_W-1:0] len);
      logic [POS_W-1:0] res;
      if (len == '0) begin
         res = POS_W'(1);
      end else if (len > POS_W'(FIELD_W)) begin
         res = POS_W'(FIELD_W);
      end else begin
         res = len;
      end
      return res;
   endfunction

   // low len bits set
   function automatic logic [FIELD_W-1:0] len_mask(input logic [POS_W-1:0] len);
      logic [POS_W-1:0] sh;
      sh = POS_W'(FIELD_W) - len;
      return {FIELD_W{1'b1}} >> sh;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/cssc_arith.sv -----
// ----------------------------------------------------------------------------
// cssc_arith
// Shared shift-add multiplier and restoring divider with round to nearest.
// ----------------------------------------------------------------------------
`default_nettype none

module cssc_arith (
   input  logic                          clock,
   input  cssc_pkg::arith_cmd_type       cmd,
   input  logic [cssc_pkg::OPA_W-1:0]    opa,
   input  logic [cssc_pkg::SCALE_W-1:0]  mpl,
   input  logic [cssc_pkg::DVSR_W-1:0]   dvsr,
   output logic [cssc_pkg::MAG_W-1:0]    mag
);
   import cssc_pkg::*;

   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [ACC_W-1:0]   mcand_ff, mcand_in;
   logic [SCALE_W-1:0] mpl_ff, mpl_in;
   logic [DVSR_W-1:0]  rem_ff, rem_in;
   logic [DVSR_W-1:0]  dvsr_ff, dvsr_in;

   logic [ACC_W-1:0]   add_x, add_y;
   logic               add_sub;
   logic [ACC_W:0]     add_sum;
   logic               add_ge;
   logic               rnd;

   // the one adder, subtracting when add_sub is set; carry out means x >= y
   assign add_sum = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)}
                    + {{ACC_W{1'b0}}, add_sub};
   assign add_ge  = add_sum[ACC_W];

   // round up when twice the remainder reaches the divisor
   assign rnd = {rem_ff, 1'b0} >= {1'b0, dvsr_ff};

   // operand select and register update
   always_comb begin
      acc_in   = acc_ff;
      mcand_in = mcand_ff;
      mpl_in   = mpl_ff;
      rem_in   = rem_ff;
      dvsr_in  = dvsr_ff;
      add_x    = acc_ff;
      add_y    = '0;
      add_sub  = 1'b0;
      case (cmd.op)
         AR_MUL_LOAD: begin
            acc_in   = '0;
            mcand_in = ACC_W'(opa);
            mpl_in   = mpl;
            dvsr_in  = dvsr;
         end
         AR_MUL_STEP: begin
            add_x    = acc_ff;
            add_y    = mpl_ff[0] ? mcand_ff : '0;
            acc_in   = add_sum[ACC_W-1:0];
            mcand_in = mcand_ff << 1;
            mpl_in   = mpl_ff >> 1;
         end
         AR_DIV_LOAD: begin
            if (cmd.wr_mode) begin
               rem_in = DVSR_W'(acc_ff[ACC_W-1:WR_STEPS]);
               acc_in = acc_ff << (ACC_W - WR_STEPS);
            end else begin
               // product scaled by 2^FRAC_BITS, aligned to the top
               rem_in = '0;
               acc_in = acc_ff << (ACC_W - RD_PROD_W);
            end
         end
         AR_DIV_STEP: begin
            add_x   = ACC_W'({rem_ff, acc_ff[ACC_W-1]});
            add_y   = ACC_W'(dvsr_ff);
            add_sub = 1'b1;
            rem_in  = add_ge ? add_sum[DVSR_W-1:0] : {rem_ff[DVSR_W-2:0], acc_ff[ACC_W-1]};
            acc_in  = {acc_ff[ACC_W-2:0], add_ge};
         end
         AR_ROUND: begin
            add_x  = cmd.wr_mode ? ACC_W'(acc_ff[WR_STEPS-1:0])
                                 : ACC_W'(acc_ff[RD_STEPS-1:0]);
            add_y  = ACC_W'(rnd);
            acc_in = add_sum[ACC_W-1:0];
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      mcand_ff <= mcand_in;
      mpl_ff   <= mpl_in;
      rem_ff   <= rem_in;
      dvsr_ff  <= dvsr_in;
   end

   assign mag = acc_ff[MAG_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/can_signal_scale_codec.sv -----
// ----------------------------------------------------------------------------
// can_signal_scale_codec
// Holds one CAN payload; loads it, reads scaled signals, writes scaled signals.
// ----------------------------------------------------------------------------
//  channel   dir  transfer carries
//  req_*     in   opcode, load payload, field position, scaling, phys value
//  rsp_*     out  phys value, payload after the item, saturated, divide error
//
//  load, unused opcode and zero-divisor items go from accept straight to the output state
//  read: 16 multiply steps, 57 divide steps in cssc_arith
//  write: 16 multiply steps, 50 divide steps in cssc_arith
//  one item at a time; req_tready is high in idle, even while a response waits
//  a stalled rsp_tready holds the finished item in the last state
//  reset clears the payload to zero and drops rsp_tvalid
// ----------------------------------------------------------------------------
`default_nettype none

module can_signal_scale_codec (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // load_payload, bit_offset, field_length, scale_mult, scale_div,
   // scale_offset, phys_in, zero pad
   input  logic [cssc_pkg::REQ_DATA_W-1:0]   req_tdata,
   // opcode, is_signed
   input  logic [cssc_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // phys_out, payload_out
   output logic [cssc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // saturated, divide_error
   output logic [cssc_pkg::RSP_USER_W-1:0]   rsp_tuser
);
   import cssc_pkg::*;

   state_type          state_ff, state_in;
   opcode_type         op_ff, op_in;
   logic [POS_W-1:0]   ofs_ff, ofs_in;
   logic [POS_W-1:0]   len_ff, len_in;
   logic               sgn_ff, sgn_in;
   logic [SCALE_W-1:0] mult_ff, mult_in;
   logic [SCALE_W-1:0] dv_ff, dv_in;
   logic [SCALE_W-1:0] soff_ff, soff_in;
   logic [PHYS_W-1:0]  phys_in_ff, phys_in_in;
   logic [PAY_W-1:0]   payload_ff, payload_in;
   logic [DIFF_W-1:0]  diff_ff, diff_in;
   logic [OPA_W-1:0]   a_ff, a_in;
   logic               neg_ff, neg_in;
   logic               big_ff, big_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [PHYS_W-1:0]  phys_res_ff, phys_res_in;
   logic               sat_res_ff, sat_res_in;
   logic               derr_res_ff, derr_res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;

   arith_cmd_type      cmd;
   logic [MAG_W-1:0]   mag;

   logic               rd_mode;
   logic [FIELD_W-1:0] lmask;
   logic [4:0]         sign_idx;
   logic [FIELD_W-1:0] field_bits;
   logic [DIFF_W-1:0]  raw_ext;
   logic [DIFF_W-1:0]  rd_diff;
   logic [DIFF_W-1:0]  wr_diff;
   logic [OPA_W-1:0]   abs_val;
   logic [SCALE_W-1:0] mpl_sel;
   logic [DVSR_W-1:0]  dvsr_sel;
   logic [BIG_W-1:0]   big_rhs;
   logic [MAG_W-1:0]   lim;
   logic [MAG_W-1:0]   rd_mag;
   logic [PHYS_W-1:0]  rd_phys;
   logic [FIELD_W-1:0] half;
   logic [FIELD_W-1:0] fmag;
   logic [FIELD_W-1:0] fbits;
   logic               wr_neg;
   logic               wsat;
   logic [PAY_W-1:0]   new_payload;
   logic               last_div;

   assign rd_mode  = (op_ff == OP_READ);
   assign lmask    = len_mask(len_ff);
   assign sign_idx = 5'(len_ff - POS_W'(1));

   // field extraction and sign extension for reads
   assign field_bits = FIELD_W'(payload_ff >> ofs_ff) & lmask;
   assign raw_ext    = (sgn_ff && field_bits[sign_idx])
                       ? {{(DIFF_W-FIELD_W){1'b1}}, (field_bits | ~lmask)}
                       : DIFF_W'(field_bits);
   assign rd_diff    = raw_ext + DIFF_W'(soff_ff);

   // physical value minus scaled offset for writes
   assign wr_diff = {phys_in_ff[PHYS_W-1], phys_in_ff} - (DIFF_W'(soff_ff) << FRAC_BITS);

   // magnitude of the signed difference
   assign abs_val = OPA_W'(diff_ff[DIFF_W-1] ? (~diff_ff + DIFF_W'(1)) : diff_ff);

   // read scales by mult/div, write by div/(mult*2^FRAC_BITS)
   assign mpl_sel  = rd_mode ? mult_ff : dv_ff;
   assign dvsr_sel = rd_mode ? DVSR_W'(dv_ff) : (DVSR_W'(mult_ff) << FRAC_BITS);

   // write quotient beyond 2^33 counts as out of any field range
   assign big_rhs = (BIG_W'(dvsr_sel) << BIG_SHIFT) + BIG_W'(dvsr_sel);

   // read clamp to the signed physical range
   assign lim = MAG_W'(1) << (PHYS_W - 1);
   always_comb begin
      if (neg_ff) begin
         rd_mag = (mag > lim) ? lim : mag;
      end else begin
         rd_mag = (mag > (lim - MAG_W'(1))) ? (lim - MAG_W'(1)) : mag;
      end
      rd_phys = neg_ff ? PHYS_W'(~rd_mag + MAG_W'(1)) : PHYS_W'(rd_mag);
   end

   // write saturation to the field range
   assign half   = FIELD_W'(1) << sign_idx;
   assign wr_neg = neg_ff && (big_ff || (mag != '0));
   always_comb begin
      fbits = '0;
      fmag  = '0;
      wsat  = 1'b0;
      if (!sgn_ff) begin
         if (wr_neg) begin
            wsat = 1'b1;
         end else if (big_ff || (mag > MAG_W'(lmask))) begin
            fbits = lmask;
            wsat  = 1'b1;
         end else begin
            fbits = FIELD_W'(mag);
         end
      end else if (wr_neg) begin
         if (big_ff || (mag > MAG_W'(half))) begin
            fmag = half;
            wsat = 1'b1;
         end else begin
            fmag = FIELD_W'(mag);
         end
         fbits = (~fmag + FIELD_W'(1)) & lmask;
      end else begin
         if (big_ff || (mag > MAG_W'(half - FIELD_W'(1)))) begin
            fbits = half - FIELD_W'(1);
            wsat  = 1'b1;
         end else begin
            fbits = FIELD_W'(mag);
         end
      end
   end

   // clear the field and insert, bits past 63 fall off
   assign new_payload = (payload_ff & ~(PAY_W'(lmask) << ofs_ff))
                        | (PAY_W'(fbits & lmask) << ofs_ff);

   assign last_div = rd_mode ? (cnt_ff == CNT_W'(RD_STEPS - 1))
                             : (cnt_ff == CNT_W'(WR_STEPS - 1));

   // sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      ofs_in       = ofs_ff;
      len_in       = len_ff;
      sgn_in       = sgn_ff;
      mult_in      = mult_ff;
      dv_in        = dv_ff;
      soff_in      = soff_ff;
      phys_in_in   = phys_in_ff;
      payload_in   = payload_ff;
      diff_in      = diff_ff;
      a_in         = a_ff;
      neg_in       = neg_ff;
      big_in       = big_ff;
      cnt_in       = cnt_ff;
      phys_res_in  = phys_res_ff;
      sat_res_in   = sat_res_ff;
      derr_res_in  = derr_res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      cmd.op       = AR_HOLD;
      cmd.wr_mode  = (op_ff == OP_WRITE);
      req_tready   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op_in       = opcode_type'(req_tuser[OPC_W-1:0]);
               sgn_in      = req_tuser[RQ_SGN_BIT];
               ofs_in      = req_tdata[RQ_OFS_LSB +: POS_W];
               len_in      = eff_len(req_tdata[RQ_LEN_LSB +: POS_W]);
               mult_in     = req_tdata[RQ_MULT_LSB +: SCALE_W];
               dv_in       = req_tdata[RQ_DIV_LSB +: SCALE_W];
               soff_in     = req_tdata[RQ_SOFF_LSB +: SCALE_W];
               phys_in_in  = req_tdata[RQ_PHYS_LSB +: PHYS_W];
               phys_res_in = '0;
               sat_res_in  = 1'b0;
               derr_res_in = 1'b0;
               state_in    = ST_OUT;
               case (opcode_type'(req_tuser[OPC_W-1:0]))
                  OP_LOAD: begin
                     payload_in = req_tdata[RQ_LOAD_LSB +: PAY_W];
                  end
                  OP_READ: begin
                     if (req_tdata[RQ_DIV_LSB +: SCALE_W] == '0) begin
                        derr_res_in = 1'b1;
                     end else begin
                        state_in = ST_SETUP;
                     end
                  end
                  OP_WRITE: begin
                     if (req_tdata[RQ_MULT_LSB +: SCALE_W] == '0) begin
                        derr_res_in = 1'b1;
                     end else begin
                        state_in = ST_SETUP;
                     end
                  end
                  default: begin
                     state_in = ST_OUT;
                  end
               endcase
            end
         end
         ST_SETUP: begin
            diff_in  = rd_mode ? rd_diff : wr_diff;
            state_in = ST_ABS;
         end
         ST_ABS: begin
            neg_in   = diff_ff[DIFF_W-1];
            a_in     = abs_val;
            cmd.op   = AR_MUL_LOAD;
            cnt_in   = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.op = AR_MUL_STEP;
            big_in = !rd_mode && (BIG_W'(a_ff) >= big_rhs);
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(SCALE_W - 1)) begin
               state_in = ST_DIV_LOAD;
            end
         end
         ST_DIV_LOAD: begin
            cmd.op   = AR_DIV_LOAD;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.op = AR_DIV_STEP;
            cnt_in = cnt_ff + CNT_W'(1);
            if (last_div) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            cmd.op   = AR_ROUND;
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            if (rd_mode) begin
               phys_res_in = rd_phys;
            end else begin
               payload_in = new_payload;
               sat_res_in = wsat;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // wait for the output register to be free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({payload_ff, phys_res_ff});
               rsp_user_in  = {derr_res_ff, sat_res_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         payload_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         payload_ff   <= payload_in;
      end
   end

   // item and result registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      ofs_ff      <= ofs_in;
      len_ff      <= len_in;
      sgn_ff      <= sgn_in;
      mult_ff     <= mult_in;
      dv_ff       <= dv_in;
      soff_ff     <= soff_in;
      phys_in_ff  <= phys_in_in;
      diff_ff     <= diff_in;
      a_ff        <= a_in;
      neg_ff      <= neg_in;
      big_ff      <= big_in;
      cnt_ff      <= cnt_in;
      phys_res_ff <= phys_res_in;
      sat_res_ff  <= sat_res_in;
      derr_res_ff <= derr_res_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   cssc_arith u_arith (
      .clock (clock),
      .cmd   (cmd),
      .opa   (abs_val),
      .mpl   (mpl_sel),
      .dvsr  (dvsr_sel),
      .mag   (mag)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire
